[hdl/aes_pkg.sv]
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and round functions for the aes-128 encrypt pipeline
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned Rounds = 10;

  typedef logic [BlockW-1:0] block_t;

  typedef struct packed {
    logic   vld;
    block_t state;
    block_t key;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [Rounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte n of the block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned n);
    return b[BlockW-1-8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w;
    block_t      r;
    t = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
         SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
    for (int i = 0; i < 4; i++) begin
      w = k[BlockW-1-32*i -: 32] ^ t;
      r[BlockW-1-32*i -: 32] = w;
      t = w;
    end
    return r;
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t r;
    for (int c = 0; c < 4; c++) begin
      for (int rr = 0; rr < 4; rr++) begin
        r[BlockW-1-8*(c*4+rr) -: 8] = SBOX[get_byte(s, ((c + rr) % 4) * 4 + rr)];
      end
    end
    return r;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    logic [7:0] a0, a1, a2, a3, al;
    block_t     r;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c*4);
      a1 = get_byte(s, c*4+1);
      a2 = get_byte(s, c*4+2);
      a3 = get_byte(s, c*4+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      r[BlockW-1-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
    end
    return r;
  endfunction

endpackage

[hdl/aes_if.sv]
// ----------------------------------------------------------------------------
// aes_if
// valid/ready channels for plaintext+key in and ciphertext out
// ----------------------------------------------------------------------------
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic [63:0] plaintext_hi;
  logic [63:0] plaintext_lo;
  modport source (output valid, key_hi, key_lo, plaintext_hi, plaintext_lo, input ready);
  modport sink (input valid, key_hi, key_lo, plaintext_hi, plaintext_lo, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_hi;
  logic [63:0] cipher_lo;
  modport source (output valid, cipher_hi, cipher_lo, input ready);
  modport sink (input valid, cipher_hi, cipher_lo, output ready);
endinterface

[hdl/aes128_block_encrypt_unit.sv]
// ----------------------------------------------------------------------------
// aes128_block_encrypt_unit
// fips-197 aes-128 encryption, fully unrolled chain of round cells
// ----------------------------------------------------------------------------
// One transaction in, one ciphertext out, through a chain of registers (input register
// with initial add-round-key, then ten round cells each with its own key
// expansion step). A new block is taken every cycle; the whole chain stalls
// only while the last cell holds a result that the sink has not taken.
module aes128_block_encrypt_unit (
  input logic clk,
  input logic rst,
  aes_in_if.sink    in,
  aes_out_if.source out
);
  aes_pkg::stage_t st [aes_pkg::Rounds+1];
  logic            en;

  assign en       = !st[aes_pkg::Rounds].vld || out.ready;
  assign in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].vld <= 1'b0;
    end else if (en) begin
      st[0].vld <= in.valid;
    end
    if (en) begin
      st[0].state <= {in.plaintext_hi, in.plaintext_lo} ^ {in.key_hi, in.key_lo};
      st[0].key   <= {in.key_hi, in.key_lo};
    end
  end

  for (genvar g = 0; g < aes_pkg::Rounds; g++) begin : g_cell
    aes_round_cell #(
      .RC   (aes_pkg::RCON[g]),
      .LAST (g == aes_pkg::Rounds - 1)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (st[g]),
      .cur  (st[g+1])
    );
  end

  assign out.valid     = st[aes_pkg::Rounds].vld;
  assign out.cipher_hi = st[aes_pkg::Rounds].state[aes_pkg::BlockW-1 -: aes_pkg::HalfW];
  assign out.cipher_lo = st[aes_pkg::Rounds].state[aes_pkg::HalfW-1:0];

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.cipher_hi) && $stable(out.cipher_lo))
    else $error("result changed while stalled");
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out.valid |-> in.ready)
    else $error("chain stalled with empty output");
  a_first_cell: assert property (@(posedge clk) disable iff (rst)
    in.valid && in.ready |=> st[0].vld)
    else $error("accepted block lost at input stage");
  a_cell_move: assert property (@(posedge clk) disable iff (rst)
    en && st[0].vld |=> st[1].vld)
    else $error("block lost between cells");
`endif
endmodule

[hdl/aes_round_cell.sv]
// ----------------------------------------------------------------------------
// aes_round_cell
// one round of the cipher and its round key, registered, handing on to the next cell
// ----------------------------------------------------------------------------
module aes_round_cell #(
  parameter logic [7:0] RC   = 8'h01,
  parameter bit         LAST = 1'b0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  aes_pkg::stage_t prev,
  output aes_pkg::stage_t cur
);
  aes_pkg::block_t ss, kn;

  always_comb begin
    ss = aes_pkg::sub_shift(prev.state);
    if (!LAST) begin
      ss = aes_pkg::mix_columns(ss);
    end
    kn = aes_pkg::next_key(prev.key, RC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.vld <= 1'b0;
    end else if (en) begin
      cur.vld <= prev.vld;
    end
    if (en) begin
      cur.state <= ss ^ kn;
      cur.key   <= kn;
    end
  end
endmodule
